FILE: rtl/jst_pkg.sv
// jst_pkg: shared types and codes for the job slot table
// opcodes, result codes, status and marker values, scan token control
// no dependencies
package jst_pkg;

  localparam int DEF_TABLE_SLOTS = 16;
  localparam int DEF_NUMBER_BITS = 16;

  localparam int OP_W       = 3;
  localparam int KEY_W      = 31;
  localparam int STATUS_W   = 2;
  localparam int CODE_W     = 2;
  localparam int MARK_W     = 2;
  localparam int SLOT_OUT_W = 4;

  // opcodes
  localparam logic [OP_W-1:0] OP_ADD      = 3'd0;
  localparam logic [OP_W-1:0] OP_SET      = 3'd1;
  localparam logic [OP_W-1:0] OP_REMOVE   = 3'd2;
  localparam logic [OP_W-1:0] OP_FIND_NUM = 3'd3;
  localparam logic [OP_W-1:0] OP_FIND_KEY = 3'd4;
  localparam logic [OP_W-1:0] OP_CLEAR    = 3'd5;

  // result codes
  localparam logic [CODE_W-1:0] RES_OK       = 2'd0;
  localparam logic [CODE_W-1:0] RES_FULL     = 2'd1;
  localparam logic [CODE_W-1:0] RES_NO_MATCH = 2'd2;

  // job status
  localparam logic [STATUS_W-1:0] ST_RUNNING = 2'd0;
  localparam logic [STATUS_W-1:0] ST_DONE    = 2'd2;

  // recency marker
  localparam logic [MARK_W-1:0] MARK_NONE     = 2'd0;
  localparam logic [MARK_W-1:0] MARK_CURRENT  = 2'd1;
  localparam logic [MARK_W-1:0] MARK_PREVIOUS = 2'd2;

  // valid slots seen above the hit, saturating
  localparam logic [1:0] ABOVE_NONE = 2'd0;
  localparam logic [1:0] ABOVE_ONE  = 2'd1;
  localparam logic [1:0] ABOVE_SAT  = 2'd2;

  typedef struct packed {
    logic       active;
    logic       found;
    logic [1:0] above;
  } tok_ctl_t;

  typedef struct packed {
    logic [CODE_W-1:0]     code;
    logic [KEY_W-1:0]      key;
    logic [STATUS_W-1:0]   status;
    logic [SLOT_OUT_W-1:0] slot;
    logic [MARK_W-1:0]     mark;
  } res_t;

endpackage

FILE: rtl/jst_cell.sv
// jst_cell: one table slot plus one stage of the scan token chain
// holds an entry, tests it against the broadcast command, forwards the token
// depends on jst_pkg
module jst_cell #(
  parameter int NUMBER_BITS = jst_pkg::DEF_NUMBER_BITS,
  parameter int SLOT_BITS   = 4,
  parameter int SLOT_ID     = 0
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          clr_all,
  input  logic [jst_pkg::OP_W-1:0]      op_i,
  input  logic [jst_pkg::KEY_W-1:0]     key_i,
  input  logic [NUMBER_BITS-1:0]        num_i,
  input  logic [jst_pkg::STATUS_W-1:0]  status_i,
  input  logic [NUMBER_BITS-1:0]        next_num_i,
  input  jst_pkg::tok_ctl_t             ctl_in,
  input  logic [SLOT_BITS-1:0]          slot_in,
  input  logic [NUMBER_BITS-1:0]        num_in,
  input  logic [jst_pkg::KEY_W-1:0]     key_in,
  input  logic [jst_pkg::STATUS_W-1:0]  status_in,
  output jst_pkg::tok_ctl_t             ctl_out,
  output logic [SLOT_BITS-1:0]          slot_out,
  output logic [NUMBER_BITS-1:0]        num_out,
  output logic [jst_pkg::KEY_W-1:0]     key_out,
  output logic [jst_pkg::STATUS_W-1:0]  status_out
);
  import jst_pkg::*;

  localparam logic [SLOT_BITS-1:0] MY_SLOT = SLOT_BITS'(SLOT_ID);

  logic                   valid_r;
  logic [NUMBER_BITS-1:0] num_r;
  logic [KEY_W-1:0]       key_r;
  logic [STATUS_W-1:0]    status_r;

  tok_ctl_t               ctl_r, ctl_nxt;
  logic [SLOT_BITS-1:0]   slot_r, slot_nxt;
  logic [NUMBER_BITS-1:0] tnum_r, tnum_nxt;
  logic [KEY_W-1:0]       tkey_r, tkey_nxt;
  logic [STATUS_W-1:0]    tstat_r, tstat_nxt;

  logic cond;
  logic hit;

  always_comb begin
    case (op_i)
      OP_ADD:                         cond = !valid_r;
      OP_SET, OP_REMOVE, OP_FIND_KEY: cond = valid_r && (key_r == key_i);
      OP_FIND_NUM:                    cond = valid_r && (num_r == num_i);
      default:                        cond = 1'b0;
    endcase
  end

  // lowest qualifying slot takes the token first
  assign hit = ctl_in.active && !ctl_in.found && cond;

  always_comb begin
    ctl_nxt   = ctl_in;
    slot_nxt  = slot_in;
    tnum_nxt  = num_in;
    tkey_nxt  = key_in;
    tstat_nxt = status_in;
    if (hit) begin
      ctl_nxt.found = 1'b1;
      ctl_nxt.above = ABOVE_NONE;
      slot_nxt      = MY_SLOT;
      if (op_i == OP_ADD) begin
        tnum_nxt  = next_num_i;
        tkey_nxt  = key_i;
        tstat_nxt = ST_RUNNING;
      end else begin
        tnum_nxt  = num_r;
        tkey_nxt  = key_r;
        tstat_nxt = (op_i == OP_SET) ? status_i : status_r;
      end
    end else if (ctl_in.active && ctl_in.found && valid_r && ctl_in.above != ABOVE_SAT) begin
      ctl_nxt.above = ctl_in.above + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      ctl_r   <= '0;
    end else begin
      ctl_r <= ctl_nxt;
      if (clr_all) begin
        valid_r <= 1'b0;
      end else if (hit) begin
        case (op_i)
          OP_ADD: begin
            valid_r  <= 1'b1;
            num_r    <= next_num_i;
            key_r    <= key_i;
            status_r <= ST_RUNNING;
          end
          OP_SET:    status_r <= status_i;
          OP_REMOVE: valid_r  <= 1'b0;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    slot_r  <= slot_nxt;
    tnum_r  <= tnum_nxt;
    tkey_r  <= tkey_nxt;
    tstat_r <= tstat_nxt;
  end

  assign ctl_out    = ctl_r;
  assign slot_out   = slot_r;
  assign num_out    = tnum_r;
  assign key_out    = tkey_r;
  assign status_out = tstat_r;

endmodule

FILE: rtl/job_slot_table.sv
// job_slot_table: top level of the job slot table
// command register, scan control, result staging; instantiates jst_cell
// depends on jst_pkg and jst_cell
//
// A table of TABLE_SLOTS job entries kept in a row of cells, one entry per
// cell. Add, set status, remove and the two lookups launch a token at slot 0
// that steps one cell per clock; the first cell that qualifies (lowest free
// slot for add, lowest valid match otherwise) claims it and applies the
// change, and the cells above count valid entries to form the recency marker.
// Such an operation lasts until the token has walked through the whole cell
// row. Clear all and unused opcodes skip the cell row and go straight to
// result staging. One operation is in flight at a time; a finished result
// waits in the output register while the next input is taken. The job
// number counter starts at 1 and holds at its maximum.
module job_slot_table #(
  parameter int TABLE_SLOTS = jst_pkg::DEF_TABLE_SLOTS,
  parameter int NUMBER_BITS = jst_pkg::DEF_NUMBER_BITS
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [jst_pkg::OP_W-1:0]        in_op,
  input  logic [jst_pkg::KEY_W-1:0]       in_group_key,
  input  logic [NUMBER_BITS-1:0]          in_lookup_number,
  input  logic [jst_pkg::STATUS_W-1:0]    in_new_status,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [jst_pkg::CODE_W-1:0]      out_result_code,
  output logic [NUMBER_BITS-1:0]          out_job_number,
  output logic [jst_pkg::KEY_W-1:0]       out_found_key,
  output logic [jst_pkg::STATUS_W-1:0]    out_job_status,
  output logic [jst_pkg::SLOT_OUT_W-1:0]  out_slot_index,
  output logic [jst_pkg::MARK_W-1:0]      out_recency_marker
);
  import jst_pkg::*;

  localparam int SLOT_BITS = $clog2(TABLE_SLOTS);
  localparam logic [NUMBER_BITS-1:0] NUM_MAX = {NUMBER_BITS{1'b1}};
  localparam logic [NUMBER_BITS-1:0] NUM_ONE = NUMBER_BITS'(1);

  typedef enum logic [1:0] {S_IDLE, S_SCAN, S_PUSH} state_t;

  state_t                 state_r;
  logic [OP_W-1:0]        op_r;
  logic [KEY_W-1:0]       key_r;
  logic [NUMBER_BITS-1:0] num_r;
  logic [STATUS_W-1:0]    status_r;
  logic                   start_r;
  logic [NUMBER_BITS-1:0] next_num_r;
  res_t                   pend_res_r;
  logic [NUMBER_BITS-1:0] pend_num_r;
  res_t                   out_res_r;
  logic [NUMBER_BITS-1:0] out_num_r;
  logic                   out_valid_r;

  tok_ctl_t               ctl_chain    [TABLE_SLOTS+1];
  logic [SLOT_BITS-1:0]   slot_chain   [TABLE_SLOTS+1];
  logic [NUMBER_BITS-1:0] num_chain    [TABLE_SLOTS+1];
  logic [KEY_W-1:0]       key_chain    [TABLE_SLOTS+1];
  logic [STATUS_W-1:0]    status_chain [TABLE_SLOTS+1];

  logic                               in_xfer;
  logic                               clr_all;
  logic                               scan_op;
  logic [STATUS_W-1:0]                status_clamped;
  tok_ctl_t                           end_ctl;
  logic                               scan_done;
  logic [SLOT_BITS+SLOT_OUT_W-1:0]    slot_ext;
  res_t                               scan_res;
  logic [NUMBER_BITS-1:0]             scan_num;
  logic [MARK_W-1:0]                  scan_mark;

  assign in_ready = (state_r == S_IDLE);
  assign in_xfer  = in_valid && in_ready;
  assign clr_all  = in_xfer && (in_op == OP_CLEAR);
  assign status_clamped = (in_new_status > ST_DONE) ? ST_DONE : in_new_status;

  always_comb begin
    case (in_op)
      OP_ADD, OP_SET, OP_REMOVE, OP_FIND_NUM, OP_FIND_KEY: scan_op = 1'b1;
      default:                                             scan_op = 1'b0;
    endcase
  end

  // token enters slot 0 fresh
  assign ctl_chain[0]    = '{active: start_r, found: 1'b0, above: ABOVE_NONE};
  assign slot_chain[0]   = '0;
  assign num_chain[0]    = '0;
  assign key_chain[0]    = '0;
  assign status_chain[0] = '0;

  for (genvar g = 0; g < TABLE_SLOTS; g++) begin : g_cell
    jst_cell #(
      .NUMBER_BITS (NUMBER_BITS),
      .SLOT_BITS   (SLOT_BITS),
      .SLOT_ID     (g)
    ) u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .clr_all    (clr_all),
      .op_i       (op_r),
      .key_i      (key_r),
      .num_i      (num_r),
      .status_i   (status_r),
      .next_num_i (next_num_r),
      .ctl_in     (ctl_chain[g]),
      .slot_in    (slot_chain[g]),
      .num_in     (num_chain[g]),
      .key_in     (key_chain[g]),
      .status_in  (status_chain[g]),
      .ctl_out    (ctl_chain[g+1]),
      .slot_out   (slot_chain[g+1]),
      .num_out    (num_chain[g+1]),
      .key_out    (key_chain[g+1]),
      .status_out (status_chain[g+1])
    );
  end

  assign end_ctl   = ctl_chain[TABLE_SLOTS];
  assign scan_done = end_ctl.active;
  assign slot_ext  = {SLOT_OUT_W'(0), slot_chain[TABLE_SLOTS]};

  always_comb begin
    case (end_ctl.above)
      ABOVE_NONE: scan_mark = MARK_CURRENT;
      ABOVE_ONE:  scan_mark = MARK_PREVIOUS;
      default:    scan_mark = MARK_NONE;
    endcase
  end

  always_comb begin
    scan_res = '0;
    scan_num = '0;
    if (end_ctl.found) begin
      scan_res.code   = RES_OK;
      scan_res.key    = key_chain[TABLE_SLOTS];
      scan_res.status = status_chain[TABLE_SLOTS];
      scan_res.slot   = slot_ext[SLOT_OUT_W-1:0];
      scan_res.mark   = scan_mark;
      scan_num        = num_chain[TABLE_SLOTS];
    end else begin
      scan_res.code = (op_r == OP_ADD) ? RES_FULL : RES_NO_MATCH;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      start_r     <= 1'b0;
      next_num_r  <= NUM_ONE;
      out_valid_r <= 1'b0;
    end else begin
      start_r <= 1'b0;
      // in push state the output register is reloaded below instead
      if (out_valid_r && out_ready && state_r != S_PUSH) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (in_xfer) begin
            op_r     <= in_op;
            key_r    <= in_group_key;
            num_r    <= in_lookup_number;
            status_r <= status_clamped;
            if (scan_op) begin
              start_r <= 1'b1;
              state_r <= S_SCAN;
            end else begin
              // clear all and unused opcodes answer with an all-zero ok
              pend_res_r <= '0;
              pend_num_r <= '0;
              state_r    <= S_PUSH;
            end
          end
        end
        S_SCAN: begin
          if (scan_done) begin
            pend_res_r <= scan_res;
            pend_num_r <= scan_num;
            if (op_r == OP_ADD && end_ctl.found && next_num_r != NUM_MAX) begin
              next_num_r <= next_num_r + NUM_ONE;
            end
            state_r <= S_PUSH;
          end
        end
        S_PUSH: begin
          if (!out_valid_r || out_ready) begin
            out_res_r   <= pend_res_r;
            out_num_r   <= pend_num_r;
            out_valid_r <= 1'b1;
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_valid          = out_valid_r;
  assign out_result_code    = out_res_r.code;
  assign out_job_number     = out_num_r;
  assign out_found_key      = out_res_r.key;
  assign out_job_status     = out_res_r.status;
  assign out_slot_index     = out_res_r.slot;
  assign out_recency_marker = out_res_r.mark;

`ifndef ASSERT_OFF
  a_start_in_scan : assert property (@(posedge clk) disable iff (!rst_n)
    start_r |-> state_r == S_SCAN)
    else $error("scan token launched outside scan state");

  a_done_in_scan : assert property (@(posedge clk) disable iff (!rst_n)
    scan_done |-> state_r == S_SCAN)
    else $error("token left the cell row outside scan state");

  a_counter_nonzero : assert property (@(posedge clk) disable iff (!rst_n)
    next_num_r != '0)
    else $error("job number counter wrapped to zero");

  a_counter_step : assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCAN && scan_done && op_r == OP_ADD && end_ctl.found &&
     next_num_r != NUM_MAX) |=> next_num_r == $past(next_num_r) + NUM_ONE)
    else $error("job number counter did not advance after add");

  a_no_scan_while_idle : assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE) |-> !ctl_chain[1].active)
    else $error("token in cell row while idle");
`endif

endmodule
